// ----- hw/rtl/insr_pkg.sv -----
`default_nettype none
package insr_pkg;

  // Field widths fixed by the item formats
  localparam int KEY_W   = 32;
  localparam int RANK_W  = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  // Default store depth
  localparam int DEPTH_DEF = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER_DESCENDING = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEYS_SIGNED      = 1'b1;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic ins_en;     // insert the broadcast key this cycle
    logic drain_en;   // shift the whole chain one place towards cell 0
    logic desc;       // descending order
    logic sgn;        // two's complement comparison
  } insr_ctrl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/insr_key_if.sv -----
`default_nettype none
interface insr_key_if;
  logic        valid;
  logic        ready;
  logic [31:0] key_value;
  logic        last_key;

  modport source (output valid, output key_value, output last_key, input ready);
  modport sink   (input valid, input key_value, input last_key, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/insr_sorted_if.sv -----
`default_nettype none
interface insr_sorted_if;
  logic        valid;
  logic        ready;
  logic [31:0] sorted_value;
  logic [5:0]  rank;
  logic        run_end;
  logic        overflowed;

  modport source (output valid, output sorted_value, output rank, output run_end,
                  output overflowed, input ready);
  modport sink   (input valid, input sorted_value, input rank, input run_end,
                  input overflowed, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/insr_cell.sv -----
`default_nettype none
module insr_cell (
  input  wire                        clk,
  input  wire                        rst,
  input  wire  insr_pkg::insr_ctrl_t ctrl,
  input  wire  [insr_pkg::KEY_W-1:0] ins_key,
  input  wire  [insr_pkg::KEY_W-1:0] lower_key,
  input  wire                        lower_valid,
  input  wire                        lower_shift,
  input  wire  [insr_pkg::KEY_W-1:0] upper_key,
  input  wire                        upper_valid,
  input  wire                        upper_chain,
  output logic [insr_pkg::KEY_W-1:0] key,
  output logic                       valid,
  output logic                       shift,
  output logic                       chain
);
  import insr_pkg::*;

  logic [KEY_W-1:0] x;
  logic [KEY_W-1:0] y;
  logic             precedes;
  logic             first_empty;
  logic             wr;

  // Compare the broadcast key against the held key; flip sign bits for signed order
  always_comb begin
    x = ins_key;
    y = key;
    if (ctrl.sgn) begin
      x[KEY_W-1] = ~x[KEY_W-1];
      y[KEY_W-1] = ~y[KEY_W-1];
    end
    precedes = ctrl.desc ? (x > y) : (x < y);
  end

  // Held entry moves up when the key precedes it and every entry above moves too
  assign shift       = valid && precedes && upper_chain;
  assign chain       = !valid || shift;
  assign first_empty = !valid && lower_valid;
  assign wr          = ctrl.ins_en && (shift || first_empty);

  // Hold, take the key or the lower neighbour's entry, or drain downwards
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.drain_en) begin
      valid <= upper_valid;
    end else if (wr) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.drain_en) begin
      key <= upper_key;
    end else if (wr) begin
      key <= lower_shift ? lower_key : ins_key;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/insertion_sorter_unit.sv -----
`default_nettype none
// Streaming insertion sorter. Each accepted item inserts its key into a row of
// DEPTH compare-and-shift cells in parallel, so keys are taken one per cycle
// outside a drain. An item marked last_key is inserted the same way, and the
// sorted set then leaves through the output register at one item per cycle
// unless the output stalls, cell 0 first, while the whole row shifts down; no
// key is accepted during that drain. Keys arriving with the row full are
// dropped and every item of that run carries overflowed.
// Equal keys keep their arrival order. Registers: index 0 order_descending,
// index 1 keys_signed (reset 1); write them only while the block is idle.
module insertion_sorter_unit #(
  parameter int DEPTH = insr_pkg::DEPTH_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  insr_key_if.sink                        key_in,
  insr_sorted_if.source                   sorted_out,
  input  wire                             cfg_we,
  input  wire  [insr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [insr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import insr_pkg::*;

  logic             order_descending;
  logic             keys_signed;
  logic             draining;
  logic             dropped_flag;
  logic [RANK_W-1:0] rank_cnt;

  logic [KEY_W-1:0] cell_key   [DEPTH];
  logic [DEPTH-1:0] cell_valid;
  logic [DEPTH-1:0] cell_shift;
  logic [DEPTH-1:0] cell_chain;

  insr_ctrl_t ctrl;
  logic       accept;
  logic       full;
  logic       load;
  logic       final_load;

  assign full       = cell_valid[DEPTH-1];
  assign key_in.ready = !draining;
  assign accept     = key_in.valid && key_in.ready;
  assign load       = draining && (!sorted_out.valid || sorted_out.ready);
  assign final_load = load && !cell_valid[1];

  assign ctrl.ins_en   = accept && !full;
  assign ctrl.drain_en = load;
  assign ctrl.desc     = order_descending;
  assign ctrl.sgn      = keys_signed;

  // Row of cells; each talks only to its neighbours
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] lo_key;
    logic             lo_valid;
    logic             lo_shift;
    logic [KEY_W-1:0] up_key;
    logic             up_valid;
    logic             up_chain;

    if (i == 0) begin : g_bottom
      assign lo_key   = '0;
      assign lo_valid = 1'b1;
      assign lo_shift = 1'b0;
    end else begin : g_lower
      assign lo_key   = cell_key[i-1];
      assign lo_valid = cell_valid[i-1];
      assign lo_shift = cell_shift[i-1];
    end

    if (i == DEPTH-1) begin : g_top
      assign up_key   = '0;
      assign up_valid = 1'b0;
      assign up_chain = 1'b1;
    end else begin : g_upper
      assign up_key   = cell_key[i+1];
      assign up_valid = cell_valid[i+1];
      assign up_chain = cell_chain[i+1];
    end

    insr_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .ins_key     (key_in.key_value),
      .lower_key   (lo_key),
      .lower_valid (lo_valid),
      .lower_shift (lo_shift),
      .upper_key   (up_key),
      .upper_valid (up_valid),
      .upper_chain (up_chain),
      .key         (cell_key[i]),
      .valid       (cell_valid[i]),
      .shift       (cell_shift[i]),
      .chain       (cell_chain[i])
    );
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      order_descending <= 1'b0;
      keys_signed      <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORDER_DESCENDING: order_descending <= cfg_data[0];
        CFG_KEYS_SIGNED:      keys_signed      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Run control: start the drain on a last item, flag drops, count ranks
  always_ff @(posedge clk) begin
    if (rst) begin
      draining     <= 1'b0;
      dropped_flag <= 1'b0;
      rank_cnt     <= '0;
    end else begin
      if (accept && key_in.last_key) begin
        draining <= 1'b1;
      end else if (final_load) begin
        draining <= 1'b0;
      end

      if (accept && full) begin
        dropped_flag <= 1'b1;
      end else if (final_load) begin
        dropped_flag <= 1'b0;
      end

      if (final_load) begin
        rank_cnt <= '0;
      end else if (load) begin
        rank_cnt <= rank_cnt + 1'b1;
      end
    end
  end

  // Output register: load cell 0 while draining, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      sorted_out.valid <= 1'b0;
    end else if (load) begin
      sorted_out.valid <= 1'b1;
    end else if (sorted_out.ready) begin
      sorted_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sorted_out.sorted_value <= cell_key[0];
      sorted_out.rank         <= rank_cnt;
      sorted_out.run_end      <= !cell_valid[1];
      sorted_out.overflowed   <= dropped_flag;
    end
  end

`ifndef SYNTHESIS
  // Occupied cells always form an unbroken run from cell 0
  a_valid_contiguous: assert property (@(posedge clk) disable iff (rst)
    (cell_valid & (cell_valid + 1'b1)) == '0)
    else $error("cell occupancy not contiguous");

  // A drain always has at least one stored key to emit
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    draining |-> cell_valid[0])
    else $error("draining with empty row");

  // The final item of a run leaves the row empty
  a_run_end_empties: assert property (@(posedge clk) disable iff (rst)
    final_load |=> (cell_valid == '0) && !draining && !dropped_flag)
    else $error("row not empty after run end");
`endif

endmodule
`default_nettype wire
